/* rtl/core/brw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brw_pkg: shared types and constants of the breath waveform generator
// Widths, register indexes, codes, sequencer states and the quarter-wave
// sine table.
// ----------------------------------------------------------------------------
package brw_pkg;

	localparam int PHASE_BITS       = 32;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int PERIOD_W         = 24;
	localparam int DVD_W            = PHASE_BITS + PERIOD_W;
	localparam int DVS_W            = PERIOD_W + PHASE_BITS - 16;
	localparam int ENV_W            = 17;
	localparam int SIN_IDX_W        = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int SIN_P_W          = ENV_W + SIN_IDX_W;
	localparam int FIT_W            = 26;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 15;
	localparam int OUT_W            = 56;

	localparam logic [ENV_W-1:0] ENV_ONE = 17'h10000;

	localparam logic [2:0] REG_RATE   = 3'd0;
	localparam logic [2:0] REG_INSP   = 3'd1;
	localparam logic [2:0] REG_IPAUSE = 3'd2;
	localparam logic [2:0] REG_EPAUSE = 3'd3;
	localparam logic [2:0] REG_BASE   = 3'd4;
	localparam logic [2:0] REG_AMP    = 3'd5;
	localparam logic [2:0] REG_SHAPE  = 3'd6;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	localparam logic [1:0] SHAPE_SINE   = 2'd0;
	localparam logic [1:0] SHAPE_RAMP   = 2'd1;
	localparam logic [1:0] SHAPE_SQUARE = 2'd2;
	localparam logic [1:0] SHAPE_ALT    = 2'd3;

	localparam logic [9:0]  US_PER_MS     = 10'd1000;
	localparam logic [16:0] FIT_MARGIN_US = 17'd100000;
	localparam logic [18:0] MIN_INSP_US   = 19'd300000;
	localparam logic [11:0] MIN_INSP_MS   = 12'd300;
	localparam logic [32:0] MINUTE_CUS    = 33'd6000000000;
	localparam logic [14:0] SQ_AMP_LIMIT  = 15'd12000;
	localparam logic [4:0]  FALL_PER_MS   = 5'd25;
	localparam logic [8:0]  FALL_ROUND    = 9'd500;
	localparam logic [15:0] MAX_TARGET    = 16'd45000;

	typedef enum logic [4:0] {
		S_IDLE, S_PER_DIV, S_FIT_EXP, S_EXP_DIV, S_FIT_INSP, S_INSP_DIV,
		S_INC_DIV, S_POS, S_SEG, S_T_DIV, S_SIN_A, S_SIN_B, S_TGT,
		S_DROP_DIV, S_DONE
	} state_t;

	typedef logic [ENV_W-1:0] sine_tab_t [SINE_TABLE_DEPTH+1];

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		longint unsigned x;
		longint unsigned term;
		longint sum;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x = (64'd1686629713 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2))
				/ 64'(SINE_TABLE_DEPTH);
			term = x;
			sum = longint'(x);
			for (int k = 1; k <= 7; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			sum = (sum + 8192) >>> 14;
			if (sum > 65536)
				sum = 65536;
			tab[i] = ENV_W'(sum);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* rtl/core/breath_waveform_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breath_waveform_generator_unit: open-loop breathing speed profile
//
// Input channel s_*: kind in s_tuser (tick, start, stop), elapsed_us in
// s_tdata. Every transaction yields one result on m_*: target_rpm, phase,
// envelope and running flag of the state after the command.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 rate,
// 1 insp time, 2 insp pause, 3 exp pause, 4 base, 5 amplitude, 6 shape).
// Each command runs on a sequencer around one serial divider that yields a
// quotient bit per cycle. Stop or a tick while stopped goes straight to the
// result; start runs the period division plus up to two fit divisions; a
// running tick runs the phase step division, then the segment position or,
// with square falls, the drop limit. s_tready is high only while the
// sequencer is idle.
// The result sits in an output register; the next command is taken while it
// waits, and the sequencer holds its next result while m_tvalid is high and m_tready is low.
// Reset restores the register defaults and stops the waveform.
// ----------------------------------------------------------------------------
module breath_waveform_generator_unit import brw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // elapsed_us
	input  logic [1:0]            s_tuser,   // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // target_rpm, cycle_phase, envelope, is_running
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [12:0] rate_q;
	logic [11:0] insp_q;
	logic [9:0]  ipause_q;
	logic [10:0] epause_q;
	logic [14:0] base_q;
	logic [14:0] amp_q;
	logic [1:0]  shape_q;

	logic [12:0] rate_c;
	logic [11:0] insp_c;
	logic [9:0]  ipause_c;
	logic [10:0] epause_c;
	logic [14:0] base_c;
	logic [14:0] amp_c;
	logic [1:0]  shape_c;

	logic                  running_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [15:0]           last_q;
	logic [ENV_W-1:0]      env_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [11:0]           fi_q;
	logic [10:0]           fe_q;

	logic [15:0]          elapsed_q;
	logic [DVD_W-1:0]     pos_q;
	logic                 fall_q;
	logic [ENV_W-1:0]     sin_u_q;
	logic [ENV_W-1:0]     lo_q;
	logic [ENV_W-1:0]     diff_q;
	logic [15:0]          f_q;
	logic [15:0]          desired_q;

	logic             div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;

	logic [21:0]         insp_us;
	logic [19:0]         ip_us;
	logic [20:0]         ep_us;
	logic [20:0]         fe_us;
	logic [21:0]         ins_us;
	logic [22:0]         pe_us;
	logic [PERIOD_W-1:0] ee_us;
	logic [FIT_W-1:0]    max_exp;
	logic [FIT_W-1:0]    max_exp_c;
	logic [FIT_W-1:0]    insp_room;
	logic                exp_fit;
	logic                insp_fit;
	logic                insp_big;

	logic [DVD_W-1:0] pos_d;
	logic [DVD_W-1:0] ins_sh;
	logic [DVD_W-1:0] pe_sh;
	logic [DVD_W-1:0] ee_sh;
	logic             in_rise;
	logic             in_hold;
	logic             in_fall;
	logic             seg_div;
	logic [ENV_W-1:0] seg_env;
	logic             square;

	logic [15:0]          t_clamp;
	logic [ENV_W-1:0]     t_val;
	logic [SIN_P_W-1:0]   sin_p;
	logic [SIN_IDX_W-1:0] sin_i;
	logic [32:0]          sin_prod;
	logic [31:0]          amp_prod;
	logic [15:0]          desired;
	logic                 lim_need;
	logic [10:0]          drop;
	logic                 out_load;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= 13'd1200;
			insp_q   <= 12'd1500;
			ipause_q <= '0;
			epause_q <= '0;
			base_q   <= 15'd5000;
			amp_q    <= 15'd4000;
			shape_q  <= SHAPE_SINE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RATE:   rate_q   <= cfg_data[12:0];
				REG_INSP:   insp_q   <= cfg_data[11:0];
				REG_IPAUSE: ipause_q <= cfg_data[9:0];
				REG_EPAUSE: epause_q <= cfg_data[10:0];
				REG_BASE:   base_q   <= cfg_data;
				REG_AMP:    amp_q    <= cfg_data;
				REG_SHAPE:  shape_q  <= cfg_data[1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		rate_c   = (rate_q < 13'd400) ? 13'd400 : ((rate_q > 13'd6000) ? 13'd6000 : rate_q);
		insp_c   = (insp_q < 12'd300) ? 12'd300 : ((insp_q > 12'd4000) ? 12'd4000 : insp_q);
		ipause_c = (ipause_q > 10'd1000) ? 10'd1000 : ipause_q;
		epause_c = (epause_q > 11'd2000) ? 11'd2000 : epause_q;
		base_c   = (base_q < 15'd2000) ? 15'd2000 : ((base_q > 15'd20000) ? 15'd20000 : base_q);
		amp_c    = (amp_q > 15'd25000) ? 15'd25000 : amp_q;
		shape_c  = (shape_q == SHAPE_ALT) ? SHAPE_SINE : shape_q;
	end

	// time fitting
	assign insp_us   = 22'(insp_c) * 22'(US_PER_MS);
	assign ip_us     = 20'(ipause_c) * 20'(US_PER_MS);
	assign ep_us     = 21'(epause_c) * 21'(US_PER_MS);
	assign fe_us     = 21'(fe_q) * 21'(US_PER_MS);
	assign ins_us    = 22'(fi_q) * 22'(US_PER_MS);
	assign pe_us     = 23'(ins_us) + 23'(ip_us);
	assign ee_us     = (period_q > PERIOD_W'(fe_us)) ? period_q - PERIOD_W'(fe_us) : '0;
	assign max_exp   = FIT_W'(period_q) - FIT_W'(insp_us) - FIT_W'(ip_us)
		- FIT_W'(FIT_MARGIN_US);
	assign max_exp_c = max_exp[FIT_W-1] ? '0 : max_exp;
	assign exp_fit   = FIT_W'(ep_us) > max_exp_c;
	assign insp_room = FIT_W'(period_q) - FIT_W'(ip_us) - FIT_W'(fe_us)
		- FIT_W'(FIT_MARGIN_US);
	assign insp_fit  = insp_room[FIT_W-1] || (FIT_W'(insp_us) > insp_room);
	assign insp_big  = !insp_room[FIT_W-1] && (insp_room > FIT_W'(MIN_INSP_US));

	// segment decode
	assign pos_d   = DVD_W'(phase_q) * DVD_W'(period_q);
	assign ins_sh  = DVD_W'(ins_us) << PHASE_BITS;
	assign pe_sh   = DVD_W'(pe_us) << PHASE_BITS;
	assign ee_sh   = DVD_W'(ee_us) << PHASE_BITS;
	assign in_rise = pos_q < ins_sh;
	assign in_hold = pos_q < pe_sh;
	assign in_fall = pos_q < ee_sh;
	assign square  = shape_c == SHAPE_SQUARE;
	assign seg_div = !square && (in_rise || (!in_hold && in_fall));
	assign seg_env = (in_rise || in_hold) ? ENV_ONE : '0;

	assign t_clamp = (div_quo[DVD_W-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
	assign t_val   = fall_q ? ENV_ONE - ENV_W'(t_clamp) : ENV_W'(t_clamp);

	assign sin_p    = SIN_P_W'(sin_u_q) * SIN_P_W'(SINE_TABLE_DEPTH);
	assign sin_i    = sin_p[16 +: SIN_IDX_W];
	assign sin_prod = 33'(diff_q) * 33'(f_q) + 33'd32768;

	assign amp_prod = 32'(amp_c) * 32'(env_q) + 32'd32768;
	assign desired  = 16'(base_c) + amp_prod[31:16];
	assign lim_need = square && (amp_c > SQ_AMP_LIMIT) && (elapsed_q != '0)
		&& (desired < last_q);
	assign drop     = div_quo[10:0];

	assign out_load = (state_q == S_DONE) && (!m_tvalid || m_tready);
	assign s_tready = state_q == S_IDLE;

	brw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DONE;
					if (s_tuser == KIND_START) begin
						div_start = 1'b1;
						div_dvd   = DVD_W'(MINUTE_CUS) + DVD_W'(rate_c >> 1);
						div_dvs   = DVS_W'(rate_c);
						state_d   = S_PER_DIV;
					end else if (s_tuser == KIND_TICK && running_q) begin
						div_start = 1'b1;
						div_dvd   = (DVD_W'(s_tdata) << PHASE_BITS) + DVD_W'(period_q >> 1);
						div_dvs   = DVS_W'(period_q);
						state_d   = S_INC_DIV;
					end
				end
			end
			S_PER_DIV: if (div_done) state_d = S_FIT_EXP;
			S_FIT_EXP: begin
				if (exp_fit) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(max_exp_c);
					div_dvs   = DVS_W'(US_PER_MS);
					state_d   = S_EXP_DIV;
				end else begin
					state_d = S_FIT_INSP;
				end
			end
			S_EXP_DIV: if (div_done) state_d = S_FIT_INSP;
			S_FIT_INSP: begin
				if (insp_fit && insp_big) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(insp_room);
					div_dvs   = DVS_W'(US_PER_MS);
					state_d   = S_INSP_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_INSP_DIV: if (div_done) state_d = S_DONE;
			S_INC_DIV:  if (div_done) state_d = S_POS;
			S_POS:      state_d = S_SEG;
			S_SEG: begin
				if (seg_div) begin
					div_start = 1'b1;
					if (in_rise) begin
						div_dvd = pos_q;
						div_dvs = DVS_W'(ins_us) << (PHASE_BITS - 16);
					end else begin
						div_dvd = pos_q - pe_sh;
						div_dvs = DVS_W'(ee_us - PERIOD_W'(pe_us)) << (PHASE_BITS - 16);
					end
					state_d = S_T_DIV;
				end else begin
					state_d = S_TGT;
				end
			end
			S_T_DIV: begin
				if (div_done)
					state_d = (shape_c == SHAPE_RAMP) ? S_TGT : S_SIN_A;
			end
			S_SIN_A: state_d = S_SIN_B;
			S_SIN_B: state_d = S_TGT;
			S_TGT: begin
				if (lim_need) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(21'(elapsed_q) * 21'(FALL_PER_MS) + 21'(FALL_ROUND));
					div_dvs   = DVS_W'(US_PER_MS);
					state_d   = S_DROP_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DROP_DIV: if (div_done) state_d = S_DONE;
			S_DONE:     if (out_load) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			phase_q   <= '0;
			last_q    <= '0;
			env_q     <= '0;
			period_q  <= PERIOD_W'(5000000);
			fi_q      <= 12'd1500;
			fe_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tuser == KIND_START) begin
						running_q <= 1'b1;
						phase_q   <= '0;
						env_q     <= '0;
						last_q    <= 16'(base_c);
					end else if (s_tvalid && s_tuser == KIND_STOP) begin
						running_q <= 1'b0;
						env_q     <= '0;
						last_q    <= 16'(base_c);
					end
				end
				S_PER_DIV: if (div_done) period_q <= div_quo[PERIOD_W-1:0];
				S_FIT_EXP: begin
					fi_q <= insp_c;
					if (!exp_fit)
						fe_q <= epause_c;
				end
				S_EXP_DIV:  if (div_done) fe_q <= div_quo[10:0];
				S_FIT_INSP: if (insp_fit && !insp_big) fi_q <= MIN_INSP_MS;
				S_INSP_DIV: if (div_done) fi_q <= div_quo[11:0];
				S_INC_DIV:  if (div_done) phase_q <= phase_q + div_quo[PHASE_BITS-1:0];
				S_SEG:      if (!seg_div) env_q <= seg_env;
				S_T_DIV:    if (div_done && shape_c == SHAPE_RAMP) env_q <= t_val;
				S_SIN_B:    env_q <= lo_q + ENV_W'(sin_prod >> 16);
				S_TGT:      if (!lim_need) last_q <= desired;
				S_DROP_DIV: begin
					if (div_done) begin
						if (17'(desired_q) + 17'(drop) < 17'(last_q))
							last_q <= last_q - 16'(drop);
						else
							last_q <= desired_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid)
			elapsed_q <= s_tdata;
		if (state_q == S_POS)
			pos_q <= pos_d;
		if (state_q == S_SEG)
			fall_q <= !in_rise;
		if (state_q == S_T_DIV && div_done)
			sin_u_q <= t_val;
		if (state_q == S_SIN_A) begin
			f_q <= sin_p[15:0];
			if (sin_i >= SIN_IDX_W'(SINE_TABLE_DEPTH)) begin
				lo_q   <= SINE_TAB[SINE_TABLE_DEPTH];
				diff_q <= '0;
			end else begin
				lo_q   <= SINE_TAB[sin_i];
				diff_q <= SINE_TAB[sin_i + 1'b1] - SINE_TAB[sin_i];
			end
		end
		if (state_q == S_TGT)
			desired_q <= desired;
		if (out_load)
			m_tdata <= {6'b0, running_q, env_q, phase_q[PHASE_BITS-1 -: 16], last_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (out_load)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

endmodule

/* rtl/core/brw_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brw_div: shared restoring divider
// One quotient bit per cycle; done rises once all DVD_W quotient bits are in and holds until the next start.
// ----------------------------------------------------------------------------
module brw_div import brw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DVD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/brw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brw_checker: port-level checks of the breath waveform generator
// Attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module brw_checker import brw_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a command was in work");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result transaction changed");

	a_stopped_env: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[49] || m_tdata[48:32] == '0))
		else $error("nonzero envelope while stopped");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] <= MAX_TARGET && m_tdata[48:32] <= ENV_ONE))
		else $error("target or envelope out of range");

endmodule

bind breath_waveform_generator_unit brw_checker u_brw_checker (.*);
